// File: src/gtg_pkg.sv
package gtg_pkg;

  // Angle constants in fixed point.
  localparam int PI_Q16     = 205887;
  localparam int PI_Q13     = 25736;
  localparam int TWO_PI_Q13 = 51472;

  // Largest legal goal coordinate, 11.1 m in Q4.11.
  localparam int GOAL_LIMIT = 22732;

  // Square root: one result bit per step, trial bit starts at 2^SQRT_TOP.
  localparam int SQRT_STEPS = 18;
  localparam int SQRT_TOP   = 34;
  localparam int SQ_W       = 36;

  // Gains are Q2.14; products are rounded half up by this constant.
  localparam int GAIN_FRAC  = 14;
  localparam int GAIN_ROUND = 8192;

  // Widths of the CORDIC datapath.
  localparam int XY_W = 32;
  localparam int Z_W  = 21;

  // Register map, one 32-bit word per register.
  typedef enum logic [2:0] {
    REG_GOAL_X            = 3'd0,
    REG_GOAL_Y            = 3'd1,
    REG_LINEAR_GAIN       = 3'd2,
    REG_ANGULAR_GAIN      = 3'd3,
    REG_HEADING_TOLERANCE = 3'd4,
    REG_ARRIVE_RADIUS     = 3'd5
  } gtg_reg_e;

  // Work carried from cell to cell along the chain.
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic [SQ_W-1:0]        rem;
    logic [SQ_W-1:0]        root;
    logic signed [15:0]     heading;
    logic                   on_goal;
    logic                   rejected;
  } gtg_work_t;

  // Arctangent of 2^-idx in Q.16 rad.
  function automatic logic [16:0] atan_q16(input int unsigned idx);
    logic [16:0] val;
    case (idx)
      0:  val = 17'd51472;
      1:  val = 17'd30386;
      2:  val = 17'd16055;
      3:  val = 17'd8150;
      4:  val = 17'd4091;
      5:  val = 17'd2047;
      6:  val = 17'd1024;
      7:  val = 17'd512;
      8:  val = 17'd256;
      9:  val = 17'd128;
      10: val = 17'd64;
      11: val = 17'd32;
      12: val = 17'd16;
      13: val = 17'd8;
      14: val = 17'd4;
      15: val = 17'd2;
      16: val = 17'd1;
      default: val = 17'd0;
    endcase
    return val;
  endfunction

endpackage

// File: src/gtg_front.sv
module gtg_front import gtg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [15:0]        goal_x_i,
  input  logic [15:0]        goal_y_i,
  input  logic               up_valid_i,
  output logic               up_ready_o,
  input  logic signed [15:0] pose_x_i,
  input  logic signed [15:0] pose_y_i,
  input  logic signed [15:0] pose_heading_i,
  output logic               dn_valid_o,
  output gtg_work_t          dn_work_o,
  input  logic               dn_ready_i
);

  // Stage A registers: offsets to the goal.
  logic               a_valid_q;
  logic signed [16:0] a_dx_q, a_dy_q;
  logic signed [15:0] a_heading_q;
  logic               a_rejected_q;
  logic               a_ready;

  // Stage B registers: squared distance and the pre-rotated vector.
  logic      b_valid_q;
  gtg_work_t b_work_q, b_work_d;
  logic      b_ready;

  logic signed [16:0] dx_d, dy_d;
  logic               rejected_d;
  logic signed [33:0] dx_sq, dy_sq;
  logic signed [XY_W-1:0] x0, y0;

  assign b_ready    = !b_valid_q || dn_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign up_ready_o = a_ready;
  assign dn_valid_o = b_valid_q;
  assign dn_work_o  = b_work_q;

  // Offsets and goal range check.
  always_comb begin
    dx_d = 17'($signed(goal_x_i)) - 17'(pose_x_i);
    dy_d = 17'($signed(goal_y_i)) - 17'(pose_y_i);
    rejected_d = goal_x_i[15] || goal_y_i[15]
              || ($signed(goal_x_i) > 16'(GOAL_LIMIT))
              || ($signed(goal_y_i) > 16'(GOAL_LIMIT));
  end

  // Squares, and a left-half-plane vector is turned by pi first.
  always_comb begin
    dx_sq = a_dx_q * a_dx_q;
    dy_sq = a_dy_q * a_dy_q;
    x0 = {{3{a_dx_q[16]}}, a_dx_q, 12'b0};
    y0 = {{3{a_dy_q[16]}}, a_dy_q, 12'b0};
    b_work_d.rem      = SQ_W'(unsigned'(dx_sq)) + SQ_W'(unsigned'(dy_sq));
    b_work_d.root     = '0;
    b_work_d.heading  = a_heading_q;
    b_work_d.on_goal  = (a_dx_q == '0) && (a_dy_q == '0);
    b_work_d.rejected = a_rejected_q;
    if (a_dx_q[16]) begin
      b_work_d.x = -x0;
      b_work_d.y = -y0;
      b_work_d.z = a_dy_q[16] ? -Z_W'(PI_Q16) : Z_W'(PI_Q16);
    end else begin
      b_work_d.x = x0;
      b_work_d.y = y0;
      b_work_d.z = '0;
    end
  end

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= up_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (a_ready && up_valid_i) begin
      a_dx_q       <= dx_d;
      a_dy_q       <= dy_d;
      a_heading_q  <= pose_heading_i;
      a_rejected_q <= rejected_d;
    end
    if (b_ready && a_valid_q) begin
      b_work_q <= b_work_d;
    end
  end

endmodule

// File: src/gtg_cell.sv
module gtg_cell import gtg_pkg::*; #(
  parameter int unsigned IDX              = 0,
  parameter int unsigned ANGLE_ITERATIONS = 14
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      up_valid_i,
  input  gtg_work_t up_work_i,
  output logic      up_ready_o,
  output logic      dn_valid_o,
  output gtg_work_t dn_work_o,
  input  logic      dn_ready_i
);

  localparam int unsigned SqrtShift = (IDX < SQRT_STEPS) ? (SQRT_TOP - 2 * IDX) : 0;
  localparam logic [SQ_W-1:0] SqrtBit = SQ_W'(1) << SqrtShift;
  localparam logic signed [Z_W-1:0] AtanStep = Z_W'(atan_q16(IDX));

  logic      valid_q;
  gtg_work_t work_q, work_d;
  logic      ready;
  logic signed [XY_W-1:0] xs, ys;
  logic [SQ_W-1:0]        trial;

  assign ready      = !valid_q || dn_ready_i;
  assign up_ready_o = ready;
  assign dn_valid_o = valid_q;
  assign dn_work_o  = work_q;

  // CORDIC vectoring step if IDX < ANGLE_ITERATIONS, square root step if IDX < SQRT_STEPS, side by side.
  always_comb begin
    work_d = up_work_i;
    xs     = up_work_i.x >>> IDX;
    ys     = up_work_i.y >>> IDX;
    trial  = up_work_i.root + SqrtBit;
    if (IDX < ANGLE_ITERATIONS) begin
      if (!up_work_i.y[XY_W-1]) begin
        work_d.x = up_work_i.x + ys;
        work_d.y = up_work_i.y - xs;
        work_d.z = up_work_i.z + AtanStep;
      end else begin
        work_d.x = up_work_i.x - ys;
        work_d.y = up_work_i.y + xs;
        work_d.z = up_work_i.z - AtanStep;
      end
    end
    if (IDX < SQRT_STEPS) begin
      if (up_work_i.rem >= trial) begin
        work_d.rem  = up_work_i.rem - trial;
        work_d.root = (up_work_i.root >> 1) + SqrtBit;
      end else begin
        work_d.root = up_work_i.root >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready && up_valid_i) begin
      work_q <= work_d;
    end
  end

endmodule

// File: src/gtg_back.sv
module gtg_back import gtg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [15:0]        linear_gain_i,
  input  logic [15:0]        angular_gain_i,
  input  logic [14:0]        heading_tolerance_i,
  input  logic [15:0]        arrive_radius_i,
  input  logic               up_valid_i,
  input  gtg_work_t          up_work_i,
  output logic               up_ready_o,
  output logic               dn_valid_o,
  input  logic               dn_ready_i,
  output logic [15:0]        linear_speed_o,
  output logic signed [15:0] angular_speed_o,
  output logic [15:0]        remaining_distance_o,
  output logic               arrived_o,
  output logic               goal_rejected_o
);

  // Stage C: heading error and comparisons.
  logic               c_valid_q, c_ready;
  logic signed [15:0] c_err_q, c_err_d;
  logic [16:0]        c_dist_q;
  logic               c_off_q, c_off_d;
  logic               c_arrived_q, c_arrived_d;
  logic               c_rejected_q;

  // Stage D: gain products.
  logic               d_valid_q, d_ready;
  logic [32:0]        d_lin_q;
  logic signed [32:0] d_ang_q;
  logic [16:0]        d_dist_q;
  logic               d_off_q, d_arrived_q, d_rejected_q;

  // Stage E: output register.
  logic               e_valid_q, e_ready;
  logic [15:0]        e_lin_q, e_lin_d;
  logic signed [15:0] e_ang_q, e_ang_d;
  logic [15:0]        e_dist_q, e_dist_d;
  logic               e_arrived_q, e_rejected_q;

  logic signed [Z_W-1:0] z_round;
  logic signed [18:0]    bearing, err0, err1, err2;
  logic [18:0]           mag;
  logic [16:0]           root_dist;
  logic [33:0]           lin_sum;
  logic [19:0]           lin_r;
  logic signed [33:0]    ang_sum, ang_r;

  assign e_ready    = !e_valid_q || dn_ready_i;
  assign d_ready    = !d_valid_q || e_ready;
  assign c_ready    = !c_valid_q || d_ready;
  assign up_ready_o = c_ready;
  assign dn_valid_o = e_valid_q;

  // Bearing rounded to Q.13, error wrapped into [-pi, pi].
  always_comb begin
    z_round = (up_work_i.z + Z_W'(4)) >>> 3;
    bearing = up_work_i.on_goal ? '0 : 19'(z_round);
    err0    = bearing - 19'(up_work_i.heading);
    if (err0 > 19'(PI_Q13)) begin
      err1 = err0 - 19'(TWO_PI_Q13);
    end else if (err0 < -19'(PI_Q13)) begin
      err1 = err0 + 19'(TWO_PI_Q13);
    end else begin
      err1 = err0;
    end
    if (err1 > 19'(PI_Q13)) begin
      err2 = err1 - 19'(TWO_PI_Q13);
    end else if (err1 < -19'(PI_Q13)) begin
      err2 = err1 + 19'(TWO_PI_Q13);
    end else begin
      err2 = err1;
    end
    mag         = err2[18] ? unsigned'(-err2) : unsigned'(err2);
    c_err_d     = err2[15:0];
    c_off_d     = mag > 19'(heading_tolerance_i);
    root_dist   = up_work_i.root[16:0];
    c_arrived_d = root_dist < 17'(arrive_radius_i);
  end

  // Rounding, saturation and gating of the speeds, and saturation of the distance.
  always_comb begin
    lin_sum = 34'(d_lin_q) + 34'(GAIN_ROUND);
    lin_r   = lin_sum[GAIN_FRAC +: 20];
    ang_sum = 34'(d_ang_q) + 34'(GAIN_ROUND);
    ang_r   = ang_sum >>> GAIN_FRAC;
    if (d_off_q || d_rejected_q) begin
      e_lin_d = '0;
    end else if (lin_r[19:16] != '0) begin
      e_lin_d = 16'hFFFF;
    end else begin
      e_lin_d = lin_r[15:0];
    end
    if (d_rejected_q) begin
      e_ang_d = '0;
    end else if (ang_r > 34'sd32767) begin
      e_ang_d = 16'sh7FFF;
    end else if (ang_r < -34'sd32768) begin
      e_ang_d = 16'sh8000;
    end else begin
      e_ang_d = ang_r[15:0];
    end
    e_dist_d = d_dist_q[16] ? 16'hFFFF : d_dist_q[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
    end else begin
      if (c_ready) begin
        c_valid_q <= up_valid_i;
      end
      if (d_ready) begin
        d_valid_q <= c_valid_q;
      end
      if (e_ready) begin
        e_valid_q <= d_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready && up_valid_i) begin
      c_err_q      <= c_err_d;
      c_dist_q     <= root_dist;
      c_off_q      <= c_off_d;
      c_arrived_q  <= c_arrived_d;
      c_rejected_q <= up_work_i.rejected;
    end
    if (d_ready && c_valid_q) begin
      d_lin_q      <= 33'(linear_gain_i) * 33'(c_dist_q);
      d_ang_q      <= $signed({1'b0, angular_gain_i}) * c_err_q;
      d_dist_q     <= c_dist_q;
      d_off_q      <= c_off_q;
      d_arrived_q  <= c_arrived_q;
      d_rejected_q <= c_rejected_q;
    end
    if (e_ready && d_valid_q) begin
      e_lin_q      <= e_lin_d;
      e_ang_q      <= e_ang_d;
      e_dist_q     <= e_dist_d;
      e_arrived_q  <= d_arrived_q;
      e_rejected_q <= d_rejected_q;
    end
  end

  assign linear_speed_o       = e_lin_q;
  assign angular_speed_o      = e_ang_q;
  assign remaining_distance_o = e_dist_q;
  assign arrived_o            = e_arrived_q;
  assign goal_rejected_o      = e_rejected_q;

endmodule

// File: src/go_to_goal_steering.sv
// Go-to-goal steering: takes one robot pose per cycle while results flow out and
// returns forward speed, turn rate, distance to the goal, an arrival flag and a
// goal-rejected flag for it. Distance and bearing come from a chain of cells of
// one module; each does a CORDIC vectoring iteration if its index is below
// ANGLE_ITERATIONS and a bit of the integer square root if it is below 18; the
// chain is max(ANGLE_ITERATIONS, 18) cells long, since the 18 root bits set its
// depth at the default setting. A request is answered after 2 front stages, that
// chain and 3 back stages. Goal, gains, tolerance and arrival radius sit in APB
// registers at byte offsets 0 to 20.
module go_to_goal_steering import gtg_pkg::*; #(
  parameter int unsigned ANGLE_ITERATIONS = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] pose_x_i,
  input  logic signed [15:0] pose_y_i,
  input  logic signed [15:0] pose_heading_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        linear_speed_o,
  output logic signed [15:0] angular_speed_o,
  output logic [15:0]        remaining_distance_o,
  output logic               arrived_o,
  output logic               goal_rejected_o
);

  localparam int unsigned NumCells =
      (ANGLE_ITERATIONS > SQRT_STEPS) ? ANGLE_ITERATIONS : SQRT_STEPS;

  logic [15:0] goal_x_q, goal_y_q, linear_gain_q, angular_gain_q, arrive_radius_q;
  logic [14:0] heading_tolerance_q;
  gtg_reg_e    reg_sel;
  logic        cfg_write;
  logic        front_ready;

  gtg_work_t          chain_work [NumCells+1];
  logic [NumCells:0]  chain_valid;
  logic [NumCells:0]  chain_ready;

  assign pready    = 1'b1;
  assign reg_sel   = gtg_reg_e'(paddr[4:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q            <= 16'd0;
      goal_y_q            <= 16'd0;
      linear_gain_q       <= 16'd8192;
      angular_gain_q      <= 16'd8192;
      heading_tolerance_q <= 15'd819;
      arrive_radius_q     <= 16'd307;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_GOAL_X:            goal_x_q            <= pwdata[15:0];
        REG_GOAL_Y:            goal_y_q            <= pwdata[15:0];
        REG_LINEAR_GAIN:       linear_gain_q       <= pwdata[15:0];
        REG_ANGULAR_GAIN:      angular_gain_q      <= pwdata[15:0];
        REG_HEADING_TOLERANCE: heading_tolerance_q <= pwdata[14:0];
        REG_ARRIVE_RADIUS:     arrive_radius_q     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (reg_sel)
      REG_GOAL_X:            prdata = 32'(goal_x_q);
      REG_GOAL_Y:            prdata = 32'(goal_y_q);
      REG_LINEAR_GAIN:       prdata = 32'(linear_gain_q);
      REG_ANGULAR_GAIN:      prdata = 32'(angular_gain_q);
      REG_HEADING_TOLERANCE: prdata = 32'(heading_tolerance_q);
      REG_ARRIVE_RADIUS:     prdata = 32'(arrive_radius_q);
      default:               prdata = '0;
    endcase
  end

  assign in_stall_o = !front_ready;

  gtg_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .goal_x_i       (goal_x_q),
    .goal_y_i       (goal_y_q),
    .up_valid_i     (in_valid_i),
    .up_ready_o     (front_ready),
    .pose_x_i       (pose_x_i),
    .pose_y_i       (pose_y_i),
    .pose_heading_i (pose_heading_i),
    .dn_valid_o     (chain_valid[0]),
    .dn_work_o      (chain_work[0]),
    .dn_ready_i     (chain_ready[0])
  );

  // The cell chain.
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    gtg_cell #(
      .IDX              (i),
      .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .up_valid_i (chain_valid[i]),
      .up_work_i  (chain_work[i]),
      .up_ready_o (chain_ready[i]),
      .dn_valid_o (chain_valid[i+1]),
      .dn_work_o  (chain_work[i+1]),
      .dn_ready_i (chain_ready[i+1])
    );
  end

  gtg_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .linear_gain_i        (linear_gain_q),
    .angular_gain_i       (angular_gain_q),
    .heading_tolerance_i  (heading_tolerance_q),
    .arrive_radius_i      (arrive_radius_q),
    .up_valid_i           (chain_valid[NumCells]),
    .up_work_i            (chain_work[NumCells]),
    .up_ready_o           (chain_ready[NumCells]),
    .dn_valid_o           (out_valid_o),
    .dn_ready_i           (!out_stall_i),
    .linear_speed_o       (linear_speed_o),
    .angular_speed_o      (angular_speed_o),
    .remaining_distance_o (remaining_distance_o),
    .arrived_o            (arrived_o),
    .goal_rejected_o      (goal_rejected_o)
  );

endmodule

// File: bench/go_to_goal_steering_tb.sv
`timescale 1ns / 1ps

module go_to_goal_steering_tb;
  import gtg_pkg::*;

  localparam int ANGLE_ITER     = 14;
  localparam int RAND_PHASES    = 12;
  localparam int PHASE_ITEMS    = 140;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;
  localparam int IDLE_PERCENT   = 29;

  // Arctangent of 2^-i in Q.16 rad for the bearing predictor.
  localparam longint ATAN_Q16 [20] = '{
    51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256, 128,
    64, 32, 16, 8, 4, 2, 1, 0, 0, 0
  };

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] heading;
  } pose_t;

  typedef struct packed {
    logic [15:0]        lin;
    logic signed [15:0] ang;
    logic [15:0]        distance;
    logic               arrived;
    logic               rejected;
  } steer_cmd_t;

  typedef struct packed {
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    pose_t              pose;
    logic               known;
    steer_cmd_t         cmd;
  } steer_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [4:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [15:0] pose_x_i;
  logic signed [15:0] pose_y_i;
  logic signed [15:0] pose_heading_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [15:0]        linear_speed_o;
  logic signed [15:0] angular_speed_o;
  logic [15:0]        remaining_distance_o;
  logic               arrived_o;
  logic               goal_rejected_o;

  // Copy of the register file as the block should hold it.
  logic signed [15:0] cur_goal_x;
  logic signed [15:0] cur_goal_y;
  logic [15:0]        cur_lin_gain;
  logic [15:0]        cur_ang_gain;
  logic [14:0]        cur_tolerance;
  logic [15:0]        cur_radius;

  steer_cmd_t cmd_expect_q[$];
  steer_row_t dir_rows[$];
  steer_cmd_t want;

  logic idle_on;
  logic hold_req;
  int   fail_count;
  int   quiet_cycles;
  int   poses_sent;
  int   cmds_checked;
  int   moving_seen;
  int   arrived_seen;
  int   rejected_seen;
  int   setups_done;

  go_to_goal_steering #(
    .ANGLE_ITERATIONS(ANGLE_ITER)
  ) u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .pose_x_i            (pose_x_i),
    .pose_y_i            (pose_y_i),
    .pose_heading_i      (pose_heading_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .linear_speed_o      (linear_speed_o),
    .angular_speed_o     (angular_speed_o),
    .remaining_distance_o(remaining_distance_o),
    .arrived_o           (arrived_o),
    .goal_rejected_o     (goal_rejected_o)
  );

  always #4 clk_i = ~clk_i;

  // Bitwise integer square root, floor of the true root.
  function automatic longint isqrt_floor(longint unsigned s);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned trial;
    rem   = s;
    root  = 0;
    trial = 64'd1 << 40;
    while (trial > s) trial = trial >> 2;
    while (trial != 0) begin
      if (rem >= root + trial) begin
        rem  = rem - (root + trial);
        root = (root >> 1) + trial;
      end else begin
        root = root >> 1;
      end
      trial = trial >> 2;
    end
    return longint'(root);
  endfunction

  // CORDIC vectoring of (dx, dy); the angle comes back in Q.13 rad.
  function automatic longint bearing_q13(longint dx, longint dy);
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    int     i;
    if (dx == 0 && dy == 0) return 0;
    x = dx * 4096;
    y = dy * 4096;
    z = 0;
    // Fold the left half plane onto the right one, starting from +pi or -pi.
    if (x < 0) begin
      z = (y >= 0) ? longint'(PI_Q16) : -longint'(PI_Q16);
      x = -x;
      y = -y;
    end
    for (i = 0; i < ANGLE_ITER && i < 20; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_Q16[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_Q16[i];
      end
    end
    return (z + 4) >>> 3;
  endfunction

  function automatic longint heading_wrap(longint e);
    while (e > PI_Q13) e = e - TWO_PI_Q13;
    while (e < -PI_Q13) e = e + TWO_PI_Q13;
    return e;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return 16'(v);
  endfunction

  // Expected steering command for one pose under the current registers.
  function automatic steer_cmd_t steer_predict(pose_t p);
    longint     gx;
    longint     gy;
    longint     dx;
    longint     dy;
    longint     d;
    longint     err;
    longint     mag;
    longint     lin;
    longint     ang;
    longint     lg;
    longint     ag;
    longint     tol;
    longint     rad;
    logic       rej;
    steer_cmd_t c;
    gx  = cur_goal_x;
    gy  = cur_goal_y;
    lg  = cur_lin_gain;
    ag  = cur_ang_gain;
    tol = cur_tolerance;
    rad = cur_radius;
    dx  = gx - longint'(p.x);
    dy  = gy - longint'(p.y);
    d   = isqrt_floor(dx * dx + dy * dy);
    err = heading_wrap(bearing_q13(dx, dy) - longint'(p.heading));
    mag = (err < 0) ? -err : err;
    rej = (gx < 0) || (gx > GOAL_LIMIT) || (gy < 0) || (gy > GOAL_LIMIT);

    lin = (lg * d + GAIN_ROUND) >>> GAIN_FRAC;
    if (lin > 65535) lin = 65535;
    if (mag > tol || rej) lin = 0;

    ang = (ag * err + GAIN_ROUND) >>> GAIN_FRAC;
    if (ang > 32767) ang = 32767;
    if (ang < -32768) ang = -32768;
    if (rej) ang = 0;

    c.lin      = lin[15:0];
    c.ang      = ang[15:0];
    c.distance = (d > 65535) ? 16'hFFFF : d[15:0];
    c.arrived  = (d < rad);
    c.rejected = rej;
    return c;
  endfunction

  // Random pose: mostly near the goal, some aimed at it, the rest anywhere.
  function automatic pose_t make_pose();
    pose_t  p;
    int     mode;
    int     reach;
    longint gx;
    longint gy;
    longint width;
    longint noise;
    gx   = cur_goal_x;
    gy   = cur_goal_y;
    mode = $urandom_range(99);
    case ($urandom_range(2))
      0:       reach = 64;
      1:       reach = 1024;
      default: reach = 8192;
    endcase
    p.heading = 16'(int'($urandom_range(0, 2 * PI_Q13)) - PI_Q13);
    if (mode < 70) begin
      p.x = clamp16(gx + int'($urandom_range(0, 2 * reach)) - reach);
      p.y = clamp16(gy + int'($urandom_range(0, 2 * reach)) - reach);
      // Point the robot close to the bearing so the tolerance edge is hit.
      if (mode < 40) begin
        width = longint'(cur_tolerance) + 64;
        noise = longint'($urandom_range(0, int'(2 * width))) - width;
        p.heading = 16'(heading_wrap(bearing_q13(gx - p.x, gy - p.y) + noise));
      end
    end else begin
      p.x = 16'($urandom);
      p.y = 16'($urandom);
    end
    return p;
  endfunction

  // One APB write: setup phase, then access phase until pready.
  task automatic reg_write(input gtg_reg_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    case (idx)
      REG_GOAL_X:            cur_goal_x    = value[15:0];
      REG_GOAL_Y:            cur_goal_y    = value[15:0];
      REG_LINEAR_GAIN:       cur_lin_gain  = value[15:0];
      REG_ANGULAR_GAIN:      cur_ang_gain  = value[15:0];
      REG_HEADING_TOLERANCE: cur_tolerance = value[14:0];
      REG_ARRIVE_RADIUS:     cur_radius    = value[15:0];
      default: ;
    endcase
  endtask

  // Wait until the block is empty, then rewrite the whole register file.
  task automatic apply_setup(input logic signed [15:0] gx, input logic signed [15:0] gy,
                             input logic [15:0] lg, input logic [15:0] ag,
                             input logic [14:0] tol, input logic [15:0] rad);
    in_valid_i <= 1'b0;
    while (cmd_expect_q.size() != 0) @(posedge clk_i);
    reg_write(REG_GOAL_X, {16'h0, gx});
    reg_write(REG_GOAL_Y, {16'h0, gy});
    reg_write(REG_LINEAR_GAIN, {16'h0, lg});
    reg_write(REG_ANGULAR_GAIN, {16'h0, ag});
    reg_write(REG_HEADING_TOLERANCE, {17'h0, tol});
    reg_write(REG_ARRIVE_RADIUS, {16'h0, rad});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    setups_done++;
  endtask

  // Offer one pose request and hold it until the block takes it.
  task automatic send_pose(input pose_t p, input logic known, input steer_cmd_t typed);
    while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    pose_x_i       <= p.x;
    pose_y_i       <= p.y;
    pose_heading_i <= p.heading;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    cmd_expect_q.push_back(known ? typed : steer_predict(p));
    poses_sent++;
  endtask

  task automatic add_row(input int gx, input int gy, input int px, input int py,
                         input int ph, input logic known, input int lin, input int ang,
                         input int distance, input logic arr, input logic rej);
    steer_row_t r;
    r.gx               = 16'(gx);
    r.gy               = 16'(gy);
    r.pose.x           = 16'(px);
    r.pose.y           = 16'(py);
    r.pose.heading     = 16'(ph);
    r.known            = known;
    r.cmd.lin          = 16'(lin);
    r.cmd.ang          = 16'(ang);
    r.cmd.distance     = 16'(distance);
    r.cmd.arrived      = arr;
    r.cmd.rejected     = rej;
    dir_rows.push_back(r);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : receiver
    out_stall_i = 1'b0;
    hold_req    = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_stall_i <= idle_on && ($urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  // Result checker and watchdog.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      cmds_checked++;
      if (cmd_expect_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected command: lin=%0d ang=%0d dist=%0d arr=%0d rej=%0d",
                   linear_speed_o, angular_speed_o, remaining_distance_o,
                   arrived_o, goal_rejected_o);
      end else begin
        want = cmd_expect_q.pop_front();
        if (want.lin !== linear_speed_o || want.ang !== angular_speed_o ||
            want.distance !== remaining_distance_o || want.arrived !== arrived_o ||
            want.rejected !== goal_rejected_o) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("mismatch at %0t: exp lin=%0d ang=%0d dist=%0d arr=%0d rej=%0d",
                     $realtime, want.lin, want.ang, want.distance, want.arrived,
                     want.rejected);
            $display("  got lin=%0d ang=%0d dist=%0d arr=%0d rej=%0d",
                     linear_speed_o, angular_speed_o, remaining_distance_o,
                     arrived_o, goal_rejected_o);
          end
        end
        if (want.lin != 0) moving_seen++;
        if (want.arrived) arrived_seen++;
        if (want.rejected) rejected_seen++;
      end
    end
    if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && out_stall_i === 1'b0))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles", quiet_cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    steer_row_t         row;
    int                 n;
    int                 ph;
    int                 k;
    logic signed [15:0] sgx;
    logic signed [15:0] sgy;
    logic [15:0]        slg;
    logic [15:0]        sag;
    logic [14:0]        stol;
    logic [15:0]        srad;

    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid_i     = 1'b0;
    pose_x_i       = '0;
    pose_y_i       = '0;
    pose_heading_i = '0;
    idle_on        = 1'b1;
    fail_count     = 0;
    quiet_cycles   = 0;
    poses_sent     = 0;
    cmds_checked   = 0;
    moving_seen    = 0;
    arrived_seen   = 0;
    rejected_seen  = 0;
    setups_done    = 0;
    cur_goal_x     = 16'sd0;
    cur_goal_y     = 16'sd0;
    cur_lin_gain   = 16'd8192;
    cur_ang_gain   = 16'd8192;
    cur_tolerance  = 15'd819;
    cur_radius     = 16'd307;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows under the reset gains; only the goal changes between rows.
    // Robot on the goal, heading at both extremes.
    add_row(0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0);
    add_row(0, 0, 0, 0, 25736, 1, 0, -12868, 0, 1, 0);
    add_row(0, 0, 0, 0, -25736, 1, 0, 12868, 0, 1, 0);
    // Pose extremes and the left half plane.
    add_row(0, 0, 32767, 32767, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, -32768, -32768, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 32767, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 32767, -12868, 0, 0, 0, 0, 0, 0);
    // Just outside and just inside the arrival radius.
    add_row(0, 0, -307, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, -306, 0, 0, 0, 0, 0, 0, 0, 0);
    // Heading error right at the tolerance and one step beyond it.
    add_row(4096, 0, 0, 0, 819, 0, 0, 0, 0, 0, 0);
    add_row(4096, 0, 0, 0, 820, 0, 0, 0, 0, 0, 0);
    add_row(4096, 0, 0, 0, -820, 0, 0, 0, 0, 0, 0);
    // Goal at the upper edge of the legal area, then distance saturation.
    add_row(22732, 22732, 22732, 22732, 0, 1, 0, 0, 0, 1, 0);
    add_row(22732, 22732, -32768, -32768, 6434, 0, 0, 0, 0, 0, 0);
    // Goals just outside the legal area on each side.
    add_row(22733, 0, 22733, 0, 0, 1, 0, 0, 0, 1, 1);
    add_row(-1, 0, 0, 0, 0, 1, 0, 0, 1, 1, 1);
    add_row(0, -1, 0, 0, 100, 1, 0, 0, 1, 1, 1);
    add_row(-32768, 32767, 32767, -32768, 0, 1, 0, 0, 65535, 0, 1);
    add_row(32767, 32767, -32768, -32768, 0, 1, 0, 0, 65535, 0, 1);
    // Bearings on the axes and the diagonals around a central goal.
    add_row(11366, 11366, 11366, 0, 12868, 0, 0, 0, 0, 0, 0);
    add_row(11366, 11366, 0, 11366, 25736, 0, 0, 0, 0, 0, 0);
    add_row(11366, 11366, 22732, 22732, -19302, 0, 0, 0, 0, 0, 0);
    add_row(11366, 11366, 22732, 0, 0, 0, 0, 0, 0, 0, 0);

    for (n = 0; n < dir_rows.size(); n++) begin
      row = dir_rows[n];
      if (row.gx != cur_goal_x || row.gy != cur_goal_y)
        apply_setup(row.gx, row.gy, cur_lin_gain, cur_ang_gain, cur_tolerance, cur_radius);
      send_pose(row.pose, row.known, row.cmd);
    end

    // Random phases, each under its own register setting.
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      if ($urandom_range(99) < 85) begin
        sgx = 16'($urandom_range(0, GOAL_LIMIT));
        sgy = 16'($urandom_range(0, GOAL_LIMIT));
      end else begin
        sgx = 16'($urandom);
        sgy = 16'($urandom);
      end
      slg  = ($urandom_range(1)) ? 16'($urandom) : 16'($urandom_range(2048, 16384));
      sag  = ($urandom_range(1)) ? 16'($urandom) : 16'($urandom_range(2048, 16384));
      stol = ($urandom_range(1)) ? 15'($urandom_range(0, PI_Q13)) :
                                   15'($urandom_range(0, 2048));
      srad = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4096));
      case (ph)
        0: begin
          slg  = 16'hFFFF;
          sag  = 16'hFFFF;
          stol = 15'(PI_Q13);
          srad = 16'hFFFF;
        end
        1: begin
          slg  = '0;
          sag  = '0;
          stol = '0;
          srad = '0;
        end
        2: begin
          sgx = 16'($urandom_range(GOAL_LIMIT + 1, 32767));
          sgy = 16'($urandom);
        end
        3: begin
          sgx = 16'sd0;
          sgy = 16'(GOAL_LIMIT);
        end
        default: ;
      endcase
      apply_setup(sgx, sgy, slg, sag, stol, srad);
      // One phase runs with no idling at all, another with a long hold-off.
      idle_on = (ph != 4);
      if (ph == 6) hold_req = 1'b1;
      for (k = 0; k < PHASE_ITEMS; k++)
        send_pose(make_pose(), 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    while (cmd_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (cmd_expect_q.size() != 0)
      $display("%0d commands never arrived", cmd_expect_q.size());
    $display("steering run: %0d poses, %0d commands checked, %0d register setups",
             poses_sent, cmds_checked, setups_done);
    $display("  %0d moving, %0d arrived, %0d goal rejected, %0d mismatches",
             moving_seen, arrived_seen, rejected_seen, fail_count);
    if (fail_count == 0 && cmd_expect_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
src/gtg_pkg.sv
src/gtg_front.sv
src/gtg_cell.sv
src/gtg_back.sv
src/go_to_goal_steering.sv
bench/go_to_goal_steering_tb.sv
